/* hdl/dvbs2_bbf_pkg.sv */
// Shared constants, codes and the CRC-8 helper of the DVB-S2 baseband framer.
// Used by dvbs2_baseband_framer_core; no dependencies.
package dvbs2_bbf_pkg;

    localparam int BYTE_W      = 8;
    localparam int KBCH_W      = 16;
    localparam int FPOS_W      = 13;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int HDR_FIELDS  = 9;     // header bytes held before the CRC byte

    localparam int QUEUE_DEPTH_DEFAULT = 8192;

    localparam logic [7:0]        PACKET_LENGTH = 8'd188;
    localparam logic [7:0]        CRC8_POLY     = 8'hD5;
    localparam logic [FPOS_W-1:0] HDR_LEN       = FPOS_W'(10);
    localparam int                HDR_BITS      = 80;
    localparam logic [15:0]       SYNCD_FULL    = 16'(187 * 8);

    // Register reset values
    localparam logic [7:0]  MATYPE_RST = 8'd240;
    localparam logic [7:0]  ISI_RST    = 8'd0;
    localparam logic [15:0] UPL_RST    = 16'd1504;
    localparam logic [15:0] DFL_RST    = 16'd58112;
    localparam logic [7:0]  SYNC_RST   = 8'd71;
    localparam logic [15:0] KBCH_RST   = 16'd58192;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        CFG_MATYPE = 3'd0,
        CFG_ISI    = 3'd1,
        CFG_UPL    = 3'd2,
        CFG_DFL    = 3'd3,
        CFG_SYNC   = 3'd4,
        CFG_KBCH   = 3'd5
    } cfg_idx_t;

    // Request kinds on the input stream
    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_PULL = 1'b1
    } req_t;

    // One byte through the CRC-8, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            fb  = b[i] ^ crc[7];
            crc = {crc[6:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC8_POLY;
            end
        end
        return crc;
    endfunction

endpackage

/* hdl/dvbs2_bbf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the framer's byte queue.
module dvbs2_bbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/dvbs2_baseband_framer_core.sv */
// DVB-S2 baseband framer core: TS packet intake, CRC-8 insertion, byte queue, BBHEADER.
// Depends on dvbs2_bbf_pkg and dvbs2_bbf_ram.
//
// Usage:
//  - Input stream (s_*): each request carries s_tuser[0] (0 = push a TS byte, 1 = pull a
//    frame byte) and s_tdata (the TS byte, ignored on pulls). The first byte of every
//    188-byte packet is the sync byte and is dropped; the other 187 bytes and their CRC-8
//    enter the byte queue.
//  - Result stream (m_*): exactly one result per request. m_tdata is the frame byte,
//    m_tuser = {push_dropped, first_of_frame, byte_valid}, m_tlast marks the last byte.
//    A pull before enough bytes are queued returns an all-zero result.
//  - Configuration via APB at byte addresses 0x00..0x14; write only while idle.
//  - Throughput: one request per cycle. Latency: the result is presented the cycle after
//    the request is accepted; queue bytes come from the RAM's registered read port.
//  - Stall: a result waits in the output register; s_tready drops only while that
//    register is full and m_tready is low.
//  - Reset clears all control state and loads register defaults; the queue RAM is not
//    cleared and needs no clearing pass.
module dvbs2_baseband_framer_core
    import dvbs2_bbf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] ts_byte
    input  logic [0:0]            s_tuser,   // [0] req_type
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] frame_byte
    output logic [2:0]            m_tuser,   // [0] byte_valid, [1] first_of_frame, [2] push_dropped
    output logic                  m_tlast,   // last_of_frame
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W = CNT_W + 4;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  cfg_matype_reg, cfg_isi_reg, cfg_sync_reg;
    logic [15:0] cfg_upl_reg, cfg_dfl_reg, cfg_kbch_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_matype_reg <= MATYPE_RST;
            cfg_isi_reg    <= ISI_RST;
            cfg_upl_reg    <= UPL_RST;
            cfg_dfl_reg    <= DFL_RST;
            cfg_sync_reg   <= SYNC_RST;
            cfg_kbch_reg   <= KBCH_RST;
        end else if (cfg_wr) begin
            case (cfg_idx_t'(paddr[4:2]))
                CFG_MATYPE: cfg_matype_reg <= pwdata[7:0];
                CFG_ISI:    cfg_isi_reg    <= pwdata[7:0];
                CFG_UPL:    cfg_upl_reg    <= pwdata[15:0];
                CFG_DFL:    cfg_dfl_reg    <= pwdata[15:0];
                CFG_SYNC:   cfg_sync_reg   <= pwdata[7:0];
                CFG_KBCH:   cfg_kbch_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (cfg_idx_t'(paddr[4:2]))
            CFG_MATYPE: prdata = APB_DATA_W'(cfg_matype_reg);
            CFG_ISI:    prdata = APB_DATA_W'(cfg_isi_reg);
            CFG_UPL:    prdata = APB_DATA_W'(cfg_upl_reg);
            CFG_DFL:    prdata = APB_DATA_W'(cfg_dfl_reg);
            CFG_SYNC:   prdata = APB_DATA_W'(cfg_sync_reg);
            CFG_KBCH:   prdata = APB_DATA_W'(cfg_kbch_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [7:0]        pkt_pos_reg, pkt_pos_next;
    logic [7:0]        pkt_crc_reg, pkt_crc_next;
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  carry_reg, carry_next;
    logic              active_reg, active_next;
    logic [FPOS_W-1:0] fpos_reg, fpos_next;
    logic [7:0]        hdr_reg [HDR_FIELDS];
    logic [7:0]        hdr_crc_reg, hdr_crc_next;
    logic              hdr_load;
    // CRC byte waiting for the write port (written the cycle after packet end)
    logic              pend_valid_reg, pend_valid_next;
    logic [PTR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [7:0]        pend_data_reg, pend_data_next;
    // result register
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_from_ram_reg, out_from_ram_next;
    logic [2:0]        out_user_reg, out_user_next;
    logic              out_last_reg, out_last_next;

    // RAM port signals
    logic              ram_we, ram_re;
    logic [PTR_W-1:0]  ram_waddr;
    logic [7:0]        ram_wdata, ram_rdata;

    dvbs2_bbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Handshake and outputs
    // ------------------------------------------------------------------
    logic accept;

    assign s_tready = ~out_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_from_ram_reg ? ram_rdata : out_byte_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Header fields built from the current registers
    // ------------------------------------------------------------------
    logic [7:0]         hdr_now [HDR_FIELDS];
    logic [CNT_W-1:0]   carry_m1;
    logic [15:0]        syncd;
    logic [FPOS_W-1:0]  kbch_bytes, payload_len, total_len;
    logic [LEN_W-1:0]   fill_bits;
    logic               fill_ok;

    assign carry_m1    = carry_reg - 1'b1;
    assign syncd       = (carry_reg == '0) ? SYNCD_FULL : {carry_m1[12:0], 3'b000};
    assign kbch_bytes  = cfg_kbch_reg[15:3];
    assign payload_len = (kbch_bytes >= HDR_LEN) ? kbch_bytes - HDR_LEN : '0;
    assign total_len   = (kbch_bytes >= HDR_LEN) ? kbch_bytes : HDR_LEN;
    assign fill_bits   = LEN_W'({count_reg, 3'b000}) + LEN_W'(HDR_BITS);
    assign fill_ok     = fill_bits >= LEN_W'(cfg_kbch_reg);

    always_comb begin
        hdr_now[0] = cfg_matype_reg;
        hdr_now[1] = cfg_matype_reg[5] ? 8'h00 : cfg_isi_reg;
        hdr_now[2] = cfg_upl_reg[15:8];
        hdr_now[3] = cfg_upl_reg[7:0];
        hdr_now[4] = cfg_dfl_reg[15:8];
        hdr_now[5] = cfg_dfl_reg[7:0];
        hdr_now[6] = cfg_sync_reg;
        hdr_now[7] = syncd[15:8];
        hdr_now[8] = syncd[7:0];
    end

    // ------------------------------------------------------------------
    // Push path helpers
    // ------------------------------------------------------------------
    logic [7:0]       pkt_crc_step;
    logic             q_full, wr_b, wr_crc;
    logic [CNT_W-1:0] count_after_b;
    logic [PTR_W-1:0] wptr_after_b;

    assign pkt_crc_step  = crc8_step(pkt_crc_reg, s_tdata);
    assign q_full        = count_reg == CNT_FULL;
    assign wr_b          = ~q_full;
    assign count_after_b = count_reg + CNT_W'(wr_b);
    assign wptr_after_b  = wr_b ? ptr_inc(wptr_reg) : wptr_reg;
    assign wr_crc        = count_after_b != CNT_FULL;

    // ------------------------------------------------------------------
    // Pull path helpers
    // ------------------------------------------------------------------
    logic [FPOS_W-1:0] pos_eff;
    logic [FPOS_W:0]   pos_plus;
    logic              frame_last;
    logic [7:0]        hdr_byte;

    assign pos_eff    = active_reg ? fpos_reg : '0;
    assign pos_plus   = {1'b0, pos_eff} + 1'b1;
    assign frame_last = pos_plus >= {1'b0, total_len};

    // header byte at the current position (first byte comes straight from the registers)
    always_comb begin
        if (pos_eff == FPOS_W'(HDR_FIELDS)) begin
            hdr_byte = hdr_crc_reg;
        end else if (!active_reg) begin
            hdr_byte = hdr_now[0];
        end else if (pos_eff < FPOS_W'(HDR_FIELDS)) begin
            hdr_byte = hdr_reg[pos_eff[3:0]];
        end else begin
            hdr_byte = 8'h00;
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        pkt_pos_next      = pkt_pos_reg;
        pkt_crc_next      = pkt_crc_reg;
        wptr_next         = wptr_reg;
        rptr_next         = rptr_reg;
        count_next        = count_reg;
        carry_next        = carry_reg;
        active_next       = active_reg;
        fpos_next         = fpos_reg;
        hdr_crc_next      = hdr_crc_reg;
        hdr_load          = 1'b0;
        pend_valid_next   = 1'b0;
        pend_addr_next    = pend_addr_reg;
        pend_data_next    = pend_data_reg;
        out_valid_next    = out_valid_reg & ~m_tready;
        out_byte_next     = out_byte_reg;
        out_from_ram_next = out_from_ram_reg;
        out_user_next     = out_user_reg;
        out_last_next     = out_last_reg;
        // pending CRC byte owns the write port by default
        ram_we            = pend_valid_reg;
        ram_waddr         = pend_addr_reg;
        ram_wdata         = pend_data_reg;
        ram_re            = 1'b0;

        if (accept) begin
            out_valid_next    = 1'b1;
            out_byte_next     = 8'h00;
            out_from_ram_next = 1'b0;
            out_user_next     = 3'b000;
            out_last_next     = 1'b0;

            if (req_t'(s_tuser[0]) == REQ_PUSH) begin
                if (pkt_pos_reg == '0 || pkt_pos_reg >= PACKET_LENGTH) begin
                    // sync byte: restart the packet CRC, nothing queued
                    pkt_crc_next = 8'h00;
                    pkt_pos_next = 8'd1;
                end else begin
                    pkt_crc_next = pkt_crc_step;
                    if (wr_b) begin
                        ram_we    = 1'b1;
                        ram_waddr = wptr_reg;
                        ram_wdata = s_tdata;
                    end
                    if (pkt_pos_reg == PACKET_LENGTH - 8'd1) begin
                        // packet end: queue the CRC through the pending slot
                        pkt_pos_next = 8'd0;
                        if (wr_crc) begin
                            pend_valid_next = 1'b1;
                            pend_addr_next  = wptr_after_b;
                            pend_data_next  = pkt_crc_step;
                            wptr_next       = ptr_inc(wptr_after_b);
                            count_next      = count_after_b + 1'b1;
                        end else begin
                            wptr_next  = wptr_after_b;
                            count_next = count_after_b;
                        end
                        out_user_next[2] = ~wr_b | ~wr_crc;
                    end else begin
                        pkt_pos_next     = pkt_pos_reg + 8'd1;
                        wptr_next        = wptr_after_b;
                        count_next       = count_after_b;
                        out_user_next[2] = ~wr_b;
                    end
                end
            end else if (active_reg || fill_ok) begin
                // frame byte; at frame start also snapshot header and record leftover count
                if (!active_reg) begin
                    hdr_load   = 1'b1;
                    carry_next = (count_reg >= CNT_W'(payload_len))
                               ? count_reg - CNT_W'(payload_len) : '0;
                end
                if (pos_eff < HDR_LEN) begin
                    out_byte_next = hdr_byte;
                    if (pos_eff < FPOS_W'(HDR_FIELDS)) begin
                        hdr_crc_next = crc8_step((pos_eff == '0) ? 8'h00 : hdr_crc_reg,
                                                 hdr_byte);
                    end
                end else if (count_reg != '0) begin
                    ram_re            = 1'b1;
                    out_from_ram_next = 1'b1;
                    rptr_next         = ptr_inc(rptr_reg);
                    count_next        = count_reg - 1'b1;
                end
                out_user_next[0] = 1'b1;
                out_user_next[1] = pos_eff == '0;
                out_last_next    = frame_last;
                if (frame_last) begin
                    active_next = 1'b0;
                    fpos_next   = '0;
                end else begin
                    active_next = 1'b1;
                    fpos_next   = pos_plus[FPOS_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_pos_reg    <= '0;
            pkt_crc_reg    <= '0;
            wptr_reg       <= '0;
            rptr_reg       <= '0;
            count_reg      <= '0;
            carry_reg      <= '0;
            active_reg     <= 1'b0;
            fpos_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pkt_pos_reg    <= pkt_pos_next;
            pkt_crc_reg    <= pkt_crc_next;
            wptr_reg       <= wptr_next;
            rptr_reg       <= rptr_next;
            count_reg      <= count_next;
            carry_reg      <= carry_next;
            active_reg     <= active_next;
            fpos_reg       <= fpos_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Data registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (hdr_load) begin
            hdr_reg <= hdr_now;
        end
        hdr_crc_reg      <= hdr_crc_next;
        pend_addr_reg    <= pend_addr_next;
        pend_data_reg    <= pend_data_next;
        out_byte_reg     <= out_byte_next;
        out_from_ram_reg <= out_from_ram_next;
        out_user_reg     <= out_user_next;
        out_last_reg     <= out_last_next;
    end

endmodule

/* dv/dvbs2_bbf_checker.sv */
// Scoreboard for the DVB-S2 baseband framer core: tracks APB writes and requests,
// models the framer state and compares every result. Depends on dvbs2_bbf_pkg.
`timescale 1ns / 1ps
module dvbs2_bbf_checker
    import dvbs2_bbf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] ts_byte
    input  logic [0:0]            s_tuser,   // [0] req_type
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,   // [7:0] frame_byte
    input  logic [2:0]            m_tuser,   // [0] byte_valid, [1] first_of_frame, [2] push_dropped
    input  logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    owed_count
);

    localparam int REPORT_CAP = 60;   // keep the log short on a badly broken build

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       byte_valid;
        logic       sof;
        logic       eof;
        logic       dropped;
    } framer_out_t;

    framer_out_t owed_responses[$];

    // configuration copy
    logic [7:0]  matype, isi, sync_byte;
    logic [15:0] upl, dfl, kbch;

    // framer state
    int          pkt_pos;
    logic [7:0]  pkt_crc;
    logic [7:0]  queued_bytes[$];
    int          leftover;
    bit          in_frame;
    int          frame_pos;
    logic [7:0]  bbheader[10];

    // CRC-8, poly 0xD5, MSB first, whole byte folded in at once
    function automatic logic [7:0] crc_byte(logic [7:0] acc, logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC8_POLY) : {r[6:0], 1'b0};
        return r;
    endfunction

    // false when the queue is full and the byte is lost
    function automatic bit queue_byte(logic [7:0] b);
        if (queued_bytes.size() >= QUEUE_DEPTH) return 1'b0;
        queued_bytes.push_back(b);
        return 1'b1;
    endfunction

    function automatic void build_bbheader();
        logic [15:0] syncd;
        logic [7:0]  c;
        bbheader[0] = matype;
        bbheader[1] = matype[5] ? 8'h00 : isi;
        bbheader[2] = upl[15:8];
        bbheader[3] = upl[7:0];
        bbheader[4] = dfl[15:8];
        bbheader[5] = dfl[7:0];
        bbheader[6] = sync_byte;
        syncd = (leftover == 0) ? SYNCD_FULL : 16'((leftover - 1) * 8);
        bbheader[7] = syncd[15:8];
        bbheader[8] = syncd[7:0];
        c = 8'h00;
        for (int i = 0; i < HDR_FIELDS; i++) c = crc_byte(c, bbheader[i]);
        bbheader[9] = c;
    endfunction

    // one request through the framer: returns its result and advances the state
    function automatic framer_out_t framer_response(req_t kind, logic [7:0] b);
        framer_out_t r;
        int payload;
        int total;
        r = '0;
        if (kind == REQ_PUSH) begin
            if (pkt_pos == 0 || pkt_pos >= int'(PACKET_LENGTH)) begin
                // sync byte: restarts the packet CRC, never queued
                pkt_crc = 8'h00;
                pkt_pos = 1;
            end else begin
                pkt_crc = crc_byte(pkt_crc, b);
                if (!queue_byte(b)) r.dropped = 1'b1;
                if (pkt_pos == int'(PACKET_LENGTH) - 1) begin
                    if (!queue_byte(pkt_crc)) r.dropped = 1'b1;
                    pkt_pos = 0;
                end else begin
                    pkt_pos++;
                end
            end
            return r;
        end

        // frame length follows the register on every pull
        payload = (int'(kbch) / 8 >= int'(HDR_LEN)) ? int'(kbch) / 8 - int'(HDR_LEN) : 0;
        total   = int'(HDR_LEN) + payload;
        if (!in_frame) begin
            if (queued_bytes.size() * 8 + HDR_BITS < int'(kbch)) return r;
            build_bbheader();
            leftover  = (queued_bytes.size() >= payload) ? queued_bytes.size() - payload : 0;
            in_frame  = 1'b1;
            frame_pos = 0;
        end

        if (frame_pos < int'(HDR_LEN)) r.frame_byte = bbheader[frame_pos];
        else if (queued_bytes.size() != 0) r.frame_byte = queued_bytes.pop_front();
        r.byte_valid = 1'b1;
        r.sof        = (frame_pos == 0);
        r.eof        = (frame_pos + 1 >= total);
        if (r.eof) begin
            in_frame  = 1'b0;
            frame_pos = 0;
        end else begin
            frame_pos = (frame_pos + 1) & 32'h1FFF;
        end
        return r;
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        framer_out_t want;
        if (!aresetn) begin
            matype    = MATYPE_RST;
            isi       = ISI_RST;
            upl       = UPL_RST;
            dfl       = DFL_RST;
            sync_byte = SYNC_RST;
            kbch      = KBCH_RST;
            pkt_pos   = 0;
            pkt_crc   = 8'h00;
            leftover  = 0;
            in_frame  = 1'b0;
            frame_pos = 0;
            queued_bytes.delete();
            owed_responses.delete();
            mismatches = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (cfg_idx_t'(paddr[4:2]))
                    CFG_MATYPE: matype    = pwdata[7:0];
                    CFG_ISI:    isi       = pwdata[7:0];
                    CFG_UPL:    upl       = pwdata[15:0];
                    CFG_DFL:    dfl       = pwdata[15:0];
                    CFG_SYNC:   sync_byte = pwdata[7:0];
                    CFG_KBCH:   kbch      = pwdata[15:0];
                    default: ;
                endcase
            end

            // results, oldest request first
            if (m_tvalid && m_tready) begin
                if (owed_responses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $error("result with no open request, frame_byte 0x%02h", m_tdata);
                end else begin
                    want = owed_responses.pop_front();
                    check_field("frame_byte", want.frame_byte, m_tdata);
                    check_field("byte_valid", want.byte_valid, m_tuser[0]);
                    check_field("first_of_frame", want.sof, m_tuser[1]);
                    check_field("push_dropped", want.dropped, m_tuser[2]);
                    check_field("last_of_frame", want.eof, m_tlast);
                end
            end

            // accepted requests
            if (s_tvalid && s_tready)
                owed_responses.push_back(framer_response(req_t'(s_tuser[0]), s_tdata));
        end
        owed_count = owed_responses.size();
    end

endmodule

/* dv/dvbs2_baseband_framer_core_test.sv */
// Top of the DVB-S2 baseband framer test: clock, reset, APB setup, request and result
// traffic. Depends on dvbs2_bbf_pkg, dvbs2_baseband_framer_core and dvbs2_bbf_checker.
`timescale 1ns / 1ps
module dvbs2_baseband_framer_core_test;
    import dvbs2_bbf_pkg::*;

    localparam int RUN_LIMIT_NS     = 6_000_000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int HOLD_PUSHES      = 188;     // one packet's worth offered during the hold
    localparam int HOLD_KBCH        = 1584;    // 188 queued bytes plus the header
    localparam int HOLD_PULLS       = 198;     // one whole frame at HOLD_KBCH
    localparam int RANDOM_REQUESTS  = 500;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] ts_byte
    logic [0:0]            s_tuser;   // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // [7:0] frame_byte
    logic [2:0]            m_tuser;   // [0] byte_valid, [1] first_of_frame, [2] push_dropped
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int owed_count;
    int burst_left;
    int pkt_idx;
    bit long_hold_wanted;

    dvbs2_baseband_framer_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dvbs2_bbf_checker scoreboard (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .mismatches(mismatches),
        .owed_count(owed_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // one request; entered and left at a falling edge, bursts separated by random gaps
    task automatic send_req(req_t kind, logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 32);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        @(negedge aclk);
    endtask

    // next byte of the running TS packet, sync byte mostly 0x47
    task automatic push_ts(logic [7:0] b);
        send_req(REQ_PUSH, b);
        pkt_idx = (pkt_idx == int'(PACKET_LENGTH) - 1) ? 0 : pkt_idx + 1;
    endtask

    task automatic push_random();
        if (pkt_idx == 0 && $urandom_range(0, 7) != 0) push_ts(8'h47);
        else push_ts(8'($urandom_range(0, 255)));
    endtask

    task automatic pull_byte();
        send_req(REQ_PULL, 8'($urandom_range(0, 255)));
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (owed_count != 0) @(negedge aclk);
    endtask

    task automatic apb_write(cfg_idx_t idx, logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // result side: segments of full rate, random, heavy and alternating stalls, one long hold
    initial begin : result_sink
        int  seg_len;
        int  mode;
        bit  held;
        m_tready = 1'b0;
        held     = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!held && long_hold_wanted) begin
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(1, 60);
            repeat (seg_len) begin
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    2:       m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ~m_tready;
                endcase
                @(negedge aclk);
            end
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("dvbs2_baseband_framer_core test failed");
        $finish;
    end

    // request side
    initial begin : stimulus
        int rand_done;
        int len;
        int push_pct;
        int kbch_bits;
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = 8'h00;
        s_tuser          = REQ_PUSH;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        burst_left       = 0;
        pkt_idx          = 0;
        long_hold_wanted = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // pull with nothing queued, then a sync byte and two extreme data bytes
        pull_byte();
        push_ts(8'h47);
        push_ts(8'h00);
        push_ts(8'hFF);

        // header-only frame: kbch below the header size, ISI sent
        drain();
        apb_write(CFG_MATYPE, 32'h00);
        apb_write(CFG_ISI, 32'hFF);
        apb_write(CFG_UPL, 32'hFFFF);
        apb_write(CFG_DFL, 32'h0000);
        apb_write(CFG_SYNC, 32'hFF);
        apb_write(CFG_KBCH, 32'd72);
        repeat (10) pull_byte();

        // odd kbch with one payload byte, ISI masked off
        drain();
        apb_write(CFG_MATYPE, 32'hFF);
        apb_write(CFG_ISI, 32'h5A);
        apb_write(CFG_UPL, 32'h0000);
        apb_write(CFG_DFL, 32'hFFFF);
        apb_write(CFG_SYNC, 32'h00);
        apb_write(CFG_KBCH, 32'd91);
        repeat (6) pull_byte();

        // grow the frame mid-way past the queue contents: empty payload bytes
        drain();
        apb_write(CFG_KBCH, 32'd123);
        repeat (7) pull_byte();

        // shrink it below the current position: next byte closes the frame
        drain();
        apb_write(CFG_KBCH, 32'd91);
        pull_byte();

        // long result hold while pushes keep coming, then read one whole frame
        drain();
        apb_write(CFG_MATYPE, 32'hF0);
        apb_write(CFG_KBCH, HOLD_KBCH);
        long_hold_wanted = 1'b1;
        repeat (HOLD_PUSHES) push_random();
        drain();
        repeat (HOLD_PULLS) pull_byte();

        // random phases: new settings, packets interleaved with pulls
        rand_done = 0;
        while (rand_done < RANDOM_REQUESTS) begin
            drain();
            if ($urandom_range(0, 1)) apb_write(CFG_MATYPE, $urandom_range(0, 255));
            if ($urandom_range(0, 1)) apb_write(CFG_ISI, $urandom_range(0, 255));
            if ($urandom_range(0, 1)) apb_write(CFG_UPL, $urandom_range(0, 65535));
            if ($urandom_range(0, 1)) apb_write(CFG_DFL, $urandom_range(0, 65535));
            if ($urandom_range(0, 1)) apb_write(CFG_SYNC, $urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:       kbch_bits = $urandom_range(0, 79);
                1:       kbch_bits = 3072;
                2:       kbch_bits = $urandom_range(3072, 3200);
                default: kbch_bits = $urandom_range(80, 480);
            endcase
            apb_write(CFG_KBCH, kbch_bits);
            len      = $urandom_range(30, 150);
            push_pct = $urandom_range(30, 70);
            repeat (len) begin
                if ($urandom_range(1, 100) <= push_pct) push_random();
                else pull_byte();
            end
            rand_done += len;
        end

        drain();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && owed_count == 0) begin
            $display("dvbs2_baseband_framer_core test passed");
        end else begin
            $display("dvbs2_baseband_framer_core test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/dvbs2_bbf_pkg.sv
hdl/dvbs2_bbf_ram.sv
hdl/dvbs2_baseband_framer_core.sv
dv/dvbs2_bbf_checker.sv
dv/dvbs2_baseband_framer_core_test.sv
